/* hdl/assert_macros.svh */
// ============================================================================
// Assertion macros
// Shared concurrent assertion helpers for the frame check RTL. Under
// SYNTHESIS the macros expand to nothing.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Checks that a condition is never true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   `ASSERT_PROP(label, clk, rst, !(expr))

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

/* hdl/mfcrc8_pkg.sv */
// ============================================================================
// Frame check package
// Types, verdict codes and the byte-wide CRC-8 step shared by the frame
// check modules.
// ============================================================================
package mfcrc8_pkg;

   // Number of leading frame bytes that carry the destination address.
   localparam logic [2:0] ADDR_BYTES = 3'd6;

   // Low byte of the generator polynomial x^8 + x^2 + x + 1.
   localparam logic [7:0] CRC_POLY_LOW = 8'h07;

   // Verdict codes.
   localparam logic [1:0] VERDICT_ACCEPT   = 2'd0;
   localparam logic [1:0] VERDICT_BAD_ADDR = 2'd1;
   localparam logic [1:0] VERDICT_BAD_CRC  = 2'd2;

   // One received byte with its end-of-frame flag.
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } frame_item_type;

   // The verdict reported on the final byte of a frame.
   typedef struct packed {
      logic [1:0] verdict;
      logic [7:0] remainder;
   } frame_result_type;

   // Shifts one byte into the remainder, most significant bit first.
   function automatic logic [7:0] crc_shift_byte(logic [7:0] rem, logic [7:0] data);
      logic [7:0] r;
      logic       out_bit;
      r = rem;
      for (int k = 7; k >= 0; k--) begin
         out_bit = r[7];
         r = {r[6:0], data[k]};
         if (out_bit) begin
            r = r ^ CRC_POLY_LOW;
         end
      end
      return r;
   endfunction

   // Selects the address byte expected at a given frame position.
   function automatic logic [7:0] address_byte(logic [47:0] addr, logic [2:0] pos);
      logic [7:0] b;
      unique case (pos)
         3'd0: b = addr[47:40];
         3'd1: b = addr[39:32];
         3'd2: b = addr[31:24];
         3'd3: b = addr[23:16];
         3'd4: b = addr[15:8];
         3'd5: b = addr[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* hdl/mfcrc8_req_if.sv */
// ============================================================================
// Frame byte channel
// Valid/ready channel that carries one received frame byte per transaction.
// ============================================================================
interface mfcrc8_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink (input valid, input frame_byte, input last_byte, output ready);

endinterface

/* hdl/mfcrc8_rsp_if.sv */
// ============================================================================
// Frame verdict channel
// Valid/ready channel that carries one frame verdict per transaction.
// ============================================================================
interface mfcrc8_rsp_if;

   logic       valid;
   logic       ready;
   logic [1:0] verdict;
   logic [7:0] remainder;

   modport source (output valid, output verdict, output remainder, input ready);
   modport sink (input valid, input verdict, input remainder, output ready);

endinterface

/* hdl/mfcrc8_frame_unit.sv */
// ============================================================================
// Frame state unit
// Holds the running remainder, byte position and address mismatch flag of
// the current frame, and works out the verdict for the byte being stepped.
// ============================================================================
module mfcrc8_frame_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  mfcrc8_pkg::frame_item_type    item,
   input  logic [47:0]                   station_address,
   output mfcrc8_pkg::frame_result_type  result
);

   import mfcrc8_pkg::*;

   logic [7:0] rem_ff;
   logic [7:0] rem_in;
   logic [2:0] pos_ff;
   logic [2:0] pos_in;
   logic       mismatch_ff;
   logic       mismatch_in;
   logic       in_address;

   // Address compare and remainder update for the byte at hand.
   always_comb begin
      in_address  = (pos_ff < ADDR_BYTES);
      mismatch_in = mismatch_ff |
                    (in_address && (address_byte(station_address, pos_ff) != item.frame_byte));
      rem_in      = (pos_ff == 3'd0) ? item.frame_byte : crc_shift_byte(rem_ff, item.frame_byte);
      pos_in      = in_address ? pos_ff + 3'd1 : pos_ff;
   end

   // Verdict: the address check wins over the remainder check.
   always_comb begin
      result.remainder = rem_in;
      priority if (mismatch_in || (pos_in < ADDR_BYTES)) begin
         result.verdict = VERDICT_BAD_ADDR;
      end else if (rem_in != 8'h00) begin
         result.verdict = VERDICT_BAD_CRC;
      end else begin
         result.verdict = VERDICT_ACCEPT;
      end
   end

   // Frame state; the final byte clears it for the next frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff      <= 8'h00;
         pos_ff      <= 3'd0;
         mismatch_ff <= 1'b0;
      end else if (step) begin
         if (item.last_byte) begin
            rem_ff      <= 8'h00;
            pos_ff      <= 3'd0;
            mismatch_ff <= 1'b0;
         end else begin
            rem_ff      <= rem_in;
            pos_ff      <= pos_in;
            mismatch_ff <= mismatch_in;
         end
      end
   end

endmodule

/* hdl/mac_filter_crc8_frame_check.sv */
// ============================================================================
// MAC filter and CRC-8 frame check
// Checks each received frame for the station address and a zero CRC-8
// remainder, and reports one verdict per frame.
// ============================================================================
// The block takes one frame byte per cycle while no final byte waits. The
// verdict is presented on the result channel from the result register, into
// which a final byte's verdict is loaded as it leaves the input register. A
// final byte waits there while an earlier verdict is unread; other bytes
// never wait in the input register. Outside such waits the throughput of
// one byte per cycle is set by the remainder update, one full byte of CRC-8
// division in a single cycle. The first six bytes must equal the station
// address (first byte against bits 47..40); the verdict is 0 for accepted,
// 1 for wrong destination (also for frames shorter than six bytes) and 2 for
// a nonzero remainder. The remainder is reported with every verdict. Write the
// station address only while no frame is in flight.
module mac_filter_crc8_frame_check (
   input  logic        clock,
   input  logic        reset,
   mfcrc8_req_if.sink  req_chan,
   mfcrc8_rsp_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data
);

   import mfcrc8_pkg::*;

`include "assert_macros.svh"

   logic [47:0]      station_address_ff;
   logic             stage_valid_ff;
   frame_item_type   stage_item_ff;
   logic             out_valid_ff;
   frame_result_type out_result_ff;
   frame_result_type step_result;
   logic             advance;
   logic             accept;

   // Station address register.
   always_ff @(posedge clock) begin
      if (reset) begin
         station_address_ff <= 48'h0;
      end else if (csr_wr_en) begin
         station_address_ff <= csr_wr_data;
      end
   end

   // The staged byte moves on unless it ends a frame and the result slot is
   // still occupied and not being read.
   assign advance = stage_valid_ff &&
                    (!stage_item_ff.last_byte || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;
   assign accept = req_chan.valid && req_chan.ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         stage_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff.frame_byte <= req_chan.frame_byte;
         stage_item_ff.last_byte  <= req_chan.last_byte;
      end
   end

   // Frame state and verdict logic.
   mfcrc8_frame_unit u_frame_unit (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .item            (stage_item_ff),
      .station_address (station_address_ff),
      .result          (step_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && stage_item_ff.last_byte) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage_item_ff.last_byte) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.verdict   = out_result_ff.verdict;
   assign rsp_chan.remainder = out_result_ff.remainder;

   // A result appears only after a final byte has been processed.
   `ASSERT_PROP(a_result_from_last, clock, reset, $rose(out_valid_ff) |-> $past(advance && stage_item_ff.last_byte))

   // Only defined verdict codes are reported.
   `ASSERT_NEVER(a_verdict_code, clock, reset, out_valid_ff && (out_result_ff.verdict > VERDICT_BAD_CRC))

   // An accepted frame always has a zero remainder.
   `ASSERT_PROP(a_accept_zero_rem, clock, reset, (out_valid_ff && (out_result_ff.verdict == VERDICT_ACCEPT)) |-> (out_result_ff.remainder == 8'h00))

   // A staged byte that cannot advance stays in the input register.
   `ASSERT_PROP(a_stage_hold, clock, reset, (stage_valid_ff && !advance) |=> (stage_valid_ff && $stable(stage_item_ff)))

endmodule
